FILE: design/vtm_pkg.sv
// Shared constants, codes and types of the virtual timer multiplexer.
`default_nettype none
package vtm_pkg;

	localparam int NUM_SLOTS   = 8;
	localparam int MAX_RESULTS = 8;
	localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
	localparam int TIME_W      = 32;
	localparam int SLOT_ID_W   = 3;
	localparam int OUT_DATA_W  = 40;

	// Input function codes
	typedef enum logic [1:0] {
		FN_TICK    = 2'd0,
		FN_ONESHOT = 2'd1,
		FN_REPEAT  = 2'd2,
		FN_UNUSED  = 2'd3
	} func_t;

	// Result kinds
	typedef enum logic [1:0] {
		EV_STARTED = 2'd0,
		EV_FULL    = 2'd1,
		EV_EXPIRED = 2'd2,
		EV_NONE    = 2'd3
	} event_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	// Control broadcast from the sequencer to every slot cell
	typedef struct packed {
		logic              tick;
		logic              start;
		logic              step;
		logic              repeat_mode;
		logic [TIME_W-1:0] interval;
		logic [TIME_W-1:0] now_cur;
		logic [TIME_W-1:0] now_next;
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: design/vtm_cell.sv
// One timer slot: expiry, period, mode, live and pending flags, scan token.
`default_nettype none
module vtm_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vtm_pkg::cell_ctrl_t ctrl,
	input  wire logic               head,      // 1 on the first cell of the row
	input  wire logic               tok_in,    // scan token from the lower neighbor
	input  wire logic               taken_in,  // a lower slot is free
	input  wire logic               later_in,  // a higher slot still has a pending fire
	output logic                    tok_out,
	output logic                    taken_out,
	output logic                    later_out,
	output logic                    due,
	output logic                    hit,
	output logic                    grant
);
	import vtm_pkg::*;

	logic              live_q;
	logic              pend_q;
	logic              tok_q;
	logic              rep_q;
	logic [TIME_W-1:0] exp_q;
	logic [TIME_W-1:0] per_q;

	// Neighbor chains and local decisions
	assign due       = live_q && (exp_q == ctrl.now_next);
	assign grant     = !live_q && !taken_in;
	assign taken_out = taken_in | !live_q;
	assign later_out = later_in | pend_q;
	assign hit       = tok_q & pend_q;
	assign tok_out   = tok_q;

	// Control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			pend_q <= 1'b0;
			tok_q  <= 1'b0;
		end else if (ctrl.tick) begin
			pend_q <= due;
			tok_q  <= head;
			if (due && !rep_q)
				live_q <= 1'b0;
		end else if (ctrl.start) begin
			if (grant)
				live_q <= 1'b1;
		end else if (ctrl.step) begin
			tok_q <= tok_in;
		end
	end

	// Timer payload: loaded on start, reloaded when a repeat timer fires
	always_ff @(posedge clk) begin
		if (ctrl.tick) begin
			if (due && rep_q)
				exp_q <= exp_q + per_q;
		end else if (ctrl.start && grant) begin
			exp_q <= ctrl.now_cur + ctrl.interval;
			per_q <= ctrl.interval;
			rep_q <= ctrl.repeat_mode;
		end
	end

endmodule
`default_nettype wire

FILE: design/virtual_timer_multiplexer_unit.sv
// Top level of the virtual timer multiplexer: slot row, scan sequencer, output register.
//
// A start word (one-shot or repeat) is answered in the next cycle with the lowest free
// slot or a table-full status; it is taken while idle and the output register is free.
// A tick word advances the shared 32-bit counter and compares every slot at once.
// If nothing falls due the block is ready again on the next cycle. Otherwise a
// token walks the row of slot cells one cell per cycle while the output register
// is free, and each due slot reports its expiry in slot order as it is passed, so
// a tick with firings keeps the input closed until the walk ends, which is at the
// last firing (or after MAX_RESULTS reports). There is no clearing pass after reset.
`default_nettype none
module virtual_timer_multiplexer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] interval
	input  wire logic [1:0]  s_tuser,   // [1:0] func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [vtm_pkg::OUT_DATA_W-1:0] m_tdata, // [2:0] slot_id, [34:3] time_now, rest 0
	output logic [1:0]       m_tuser,   // [1:0] event_res
	output logic             m_tlast
);
	import vtm_pkg::*;

	state_t            state_q;
	logic [TIME_W-1:0] now_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [1:0]        out_user_q;
	logic              out_last_q;

	cell_ctrl_t        ctrl;
	logic              s_acc;
	logic              out_free;
	logic              is_tick;
	logic              is_start;
	logic [NUM_SLOTS-1:0] tok_v, taken_v, later_v, due_v, hit_v, grant_v;
	logic [NUM_SLOTS:0]   tok_c, taken_c;
	logic [NUM_SLOTS:0]   later_c;
	logic              any_due;
	logic              any_hit;
	logic              hit_last;
	logic              full;
	logic [IDX_W-1:0]  gidx;
	logic [IDX_W+SLOT_ID_W-1:0] gidx_x, idx_x;

	// Handshake and decode
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign s_acc    = s_tvalid && s_tready;
	assign is_tick  = (s_tuser == FN_TICK);
	assign is_start = (s_tuser == FN_ONESHOT) || (s_tuser == FN_REPEAT);

	// Broadcast to the cells
	always_comb begin
		ctrl.tick        = s_acc && is_tick;
		ctrl.start       = s_acc && is_start;
		ctrl.step        = (state_q == ST_SCAN) && out_free;
		ctrl.repeat_mode = (s_tuser == FN_REPEAT);
		ctrl.interval    = s_tdata;
		ctrl.now_cur     = now_q;
		ctrl.now_next    = now_q + 32'd1;
	end

	// Row of slot cells with token, free and pending chains
	assign tok_c[0]           = 1'b0;
	assign taken_c[0]         = 1'b0;
	assign later_c[NUM_SLOTS] = 1'b0;

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		vtm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.head      ((g == 0) ? 1'b1 : 1'b0),
			.tok_in    (tok_c[g]),
			.taken_in  (taken_c[g]),
			.later_in  (later_c[g+1]),
			.tok_out   (tok_c[g+1]),
			.taken_out (taken_c[g+1]),
			.later_out (later_c[g]),
			.due       (due_v[g]),
			.hit       (hit_v[g]),
			.grant     (grant_v[g])
		);
		assign tok_v[g]   = tok_c[g+1];
		assign taken_v[g] = taken_c[g];
		assign later_v[g] = later_c[g+1];
	end

	assign any_due  = |due_v;
	assign any_hit  = |hit_v;
	assign hit_last = (|(hit_v & ~later_v)) || (cnt_q == CNT_W'(MAX_RESULTS - 1));
	assign full     = !taken_c[NUM_SLOTS];

	// Encode the granted slot
	always_comb begin
		gidx = '0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (grant_v[i])
				gidx = gidx | IDX_W'(i);
	end

	assign gidx_x = {{SLOT_ID_W{1'b0}}, gidx};
	assign idx_x  = {{SLOT_ID_W{1'b0}}, idx_q};

	// Sequencer and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q   <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctrl.tick) begin
						now_q <= ctrl.now_next;
						idx_q <= '0;
						cnt_q <= '0;
						if (any_due)
							state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ctrl.step) begin
						idx_q <= idx_q + 1'b1;
						if (any_hit) begin
							cnt_q <= cnt_q + 1'b1;
							if (hit_last)
								state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.start || (ctrl.step && any_hit))
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			out_data_q <= {5'd0, now_q, (full ? SLOT_ID_W'(0) : gidx_x[SLOT_ID_W-1:0])};
			out_user_q <= full ? EV_FULL : EV_STARTED;
			out_last_q <= 1'b1;
		end else if (ctrl.step && any_hit) begin
			out_data_q <= {5'd0, now_q, idx_x[SLOT_ID_W-1:0]};
			out_user_q <= EV_EXPIRED;
			out_last_q <= hit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	// Checks
	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(tok_v))
		else $error("scan token in more than one cell");
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(hit_v))
		else $error("more than one slot reporting at once");
	a_quiet_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.tick && !any_due) |=> (state_q == ST_IDLE))
		else $error("scan entered with nothing due");
	a_grant_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant_v & ~taken_v))
		else $error("more than one free slot granted");
	a_start_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> (m_tvalid && m_tlast))
		else $error("start answer not a single last word");

endmodule
`default_nettype wire

FILE: tb/vtm_expiry_checker.sv
// Checker for the virtual timer multiplexer: predicts start answers and expiries, compares results.
module vtm_expiry_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [31:0]                    s_tdata,   // [31:0] interval
	input  logic [1:0]                     s_tuser,   // [1:0] func
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [vtm_pkg::OUT_DATA_W-1:0] m_tdata,   // [2:0] slot_id, [34:3] time_now, rest 0
	input  logic [1:0]                     m_tuser,   // [1:0] event_res
	input  logic                           m_tlast,
	output int                             mismatches,
	output int                             results_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import vtm_pkg::*;

	typedef struct {
		event_t                 ev;
		logic [SLOT_ID_W-1:0]   slot;
		logic [TIME_W-1:0]      stamp;
		logic                   fin;
	} timer_event_t;

	// Shadow copy of the counter and slot table
	logic [TIME_W-1:0] now_cnt;
	logic [TIME_W-1:0] due_at [NUM_SLOTS];
	logic [TIME_W-1:0] reload [NUM_SLOTS];
	logic              periodic [NUM_SLOTS];
	logic              armed [NUM_SLOTS];

	timer_event_t owed_events[$];

	initial mismatches = 0;
	assign results_owed = owed_events.size();

	// Apply one accepted word to the shadow table and queue what it should produce
	task automatic apply_timer_word(input func_t fn, input logic [TIME_W-1:0] ivl);
		int           fired;
		bit           placed;
		timer_event_t ev_rec;
		fired  = 0;
		placed = 1'b0;
		case (fn)
			FN_ONESHOT, FN_REPEAT: begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (!placed && !armed[i]) begin
						armed[i]    = 1'b1;
						due_at[i]   = now_cnt + ivl;
						reload[i]   = ivl;
						periodic[i] = (fn == FN_REPEAT);
						ev_rec      = '{EV_STARTED, SLOT_ID_W'(i), now_cnt, 1'b1};
						owed_events.push_back(ev_rec);
						placed      = 1'b1;
					end
				end
				if (!placed) begin
					ev_rec = '{EV_FULL, '0, now_cnt, 1'b1};
					owed_events.push_back(ev_rec);
				end
			end
			FN_TICK: begin
				now_cnt = now_cnt + 32'd1;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (armed[i] && due_at[i] == now_cnt) begin
						if (fired < MAX_RESULTS) begin
							ev_rec = '{EV_EXPIRED, SLOT_ID_W'(i), now_cnt, 1'b0};
							owed_events.push_back(ev_rec);
							fired++;
						end
						if (periodic[i])
							due_at[i] = due_at[i] + reload[i];
						else
							armed[i] = 1'b0;
					end
				end
				// only the final firing of the tick carries last
				if (fired > 0)
					owed_events[owed_events.size()-1].fin = 1'b1;
			end
			default: ;
		endcase
	endtask

	// Predict on input words, compare on output words
	always @(posedge clk or negedge arst_n) begin
		timer_event_t want;
		if (!arst_n) begin
			now_cnt = '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				armed[i]    = 1'b0;
				periodic[i] = 1'b0;
				due_at[i]   = '0;
				reload[i]   = '0;
			end
			owed_events.delete();
		end else begin
			if (s_tvalid && s_tready)
				apply_timer_word(func_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready) begin
				if (owed_events.size() == 0) begin
					$error("unexpected result word: event_res %0d slot_id %0d time_now %0d",
						m_tuser, m_tdata[SLOT_ID_W-1:0], m_tdata[SLOT_ID_W +: TIME_W]);
					mismatches++;
				end else begin
					want = owed_events.pop_front();
					if (m_tuser !== want.ev) begin
						$error("event_res: expected %0d, got %0d", want.ev, m_tuser);
						mismatches++;
					end
					if (m_tdata[SLOT_ID_W-1:0] !== want.slot) begin
						$error("slot_id: expected %0d, got %0d", want.slot,
							m_tdata[SLOT_ID_W-1:0]);
						mismatches++;
					end
					if (m_tdata[SLOT_ID_W +: TIME_W] !== want.stamp) begin
						$error("time_now: expected %0d, got %0d", want.stamp,
							m_tdata[SLOT_ID_W +: TIME_W]);
						mismatches++;
					end
					if (m_tlast !== want.fin) begin
						$error("last: expected %0d, got %0d", want.fin, m_tlast);
						mismatches++;
					end
					if (m_tdata[OUT_DATA_W-1:SLOT_ID_W+TIME_W] !== '0) begin
						$error("tdata pad: expected 0, got %0h",
							m_tdata[OUT_DATA_W-1:SLOT_ID_W+TIME_W]);
						mismatches++;
					end
				end
			end
		end
	end

endmodule

FILE: tb/virtual_timer_multiplexer_unit_test.sv
// Testbench top for the virtual timer multiplexer: clock, reset, stimulus and verdict.
module virtual_timer_multiplexer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import vtm_pkg::*;

	localparam int RANDOM_WORDS = 460;
	localparam int STALL_LIMIT  = 1000;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata  = '0;
	logic [1:0]            s_tuser  = FN_TICK;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	int mismatches;
	int results_owed;
	int burst_left  = 0;
	int idle_cycles = 0;
	int rx_cycle    = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	virtual_timer_multiplexer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	vtm_expiry_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	// Receiver: cycles through always-ready, random, sparse and periodic stall phases
	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle / 97) % 4)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((rx_cycle % 11) >= 4);
		endcase
	end

	// Watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("virtual_timer_multiplexer_unit_test: done, errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offer one word, called at a falling edge; bursts of random length with gaps between
	task automatic send_word(input func_t fn, input logic [31:0] ivl);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= ivl;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		burst_left--;
	endtask

	// Hold the sender until every predicted result has been taken
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (results_owed != 0);
		burst_left = 0;
	endtask

	initial begin
		func_t       fn;
		logic [31:0] ivl;
		int          pick;
		int          counted;
		int          repeats_left;

		counted      = 0;
		repeats_left = 2;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: idle tick, unused code, zero and all-ones intervals, table full,
		// simultaneous expiries of repeat and one-shot timers
		send_word(FN_TICK,    32'h0000_0000);
		send_word(FN_UNUSED,  32'hFFFF_FFFF);
		send_word(FN_ONESHOT, 32'h0000_0000);
		send_word(FN_REPEAT,  32'hFFFF_FFFF);
		send_word(FN_REPEAT,  32'd3);
		send_word(FN_ONESHOT, 32'd3);
		send_word(FN_ONESHOT, 32'd3);
		send_word(FN_ONESHOT, 32'd1);
		send_word(FN_ONESHOT, 32'd5);
		send_word(FN_ONESHOT, 32'd6);
		send_word(FN_ONESHOT, 32'd9);
		send_word(FN_REPEAT,  32'd2);
		send_word(FN_TICK,    32'hFFFF_FFFF);
		send_word(FN_TICK,    32'h5555_5555);
		send_word(FN_TICK,    32'hAAAA_AAAA);
		send_word(FN_TICK,    32'h0000_0000);
		send_word(FN_TICK,    32'h8000_0001);
		send_word(FN_TICK,    32'h0000_0000);
		send_word(FN_ONESHOT, 32'd1);
		send_word(FN_ONESHOT, 32'd1);
		send_word(FN_TICK,    32'h0000_0000);
		send_word(FN_UNUSED,  32'h0000_0000);
		drain_results();

		// Random: mostly ticks and short one-shots so slots keep cycling;
		// repeat timers never free a slot, so only a couple are allowed
		while (counted < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			ivl  = $urandom;
			if (pick < 5) begin
				fn = FN_UNUSED;
			end else if (pick < 55) begin
				fn = FN_TICK;
			end else if (pick < 95 || repeats_left == 0) begin
				fn  = FN_ONESHOT;
				ivl = ($urandom_range(0, 7) == 0) ? 32'd1 : 32'($urandom_range(1, 14));
			end else begin
				fn  = FN_REPEAT;
				ivl = 32'($urandom_range(2, 9));
				repeats_left--;
			end
			send_word(fn, ivl);
			if (fn != FN_UNUSED) begin
				counted++;
				if (counted % 120 == 0)
					drain_results();
			end
		end

		// Wind down and give the verdict
		drain_results();
		repeat (NUM_SLOTS + 4) @(negedge clk);
		if (mismatches == 0 && results_owed == 0)
			$display("virtual_timer_multiplexer_unit_test: done, clean");
		else
			$display("virtual_timer_multiplexer_unit_test: done, errors");
		$finish;
	end

endmodule
